### rtl/msp_pkg.sv
// shared types and constants for the msp response frame parser
package msp_pkg;

	// header characters of a response frame
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_ARROW  = 8'h3E;
	localparam logic [7:0] CH_BANG   = 8'h21;

	// parser phase
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DOLLAR = 3'd1,
		PH_M      = 3'd2,
		PH_ARROW  = 3'd3,
		PH_ERR    = 3'd4,
		PH_SIZE   = 3'd5,
		PH_CMD    = 3'd6
	} phase_t;

	// event reported with each result
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_DATA    = 3'd1,
		EV_GOOD    = 3'd2,
		EV_GOODERR = 3'd3,
		EV_BADSUM  = 3'd4
	} event_t;

	// one result item
	typedef struct packed {
		event_t     event_res;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] command;
		logic [7:0] frame_size;
	} res_t;

endpackage

### rtl/msp_response_frame_parser_top.sv
// top level of the msp response frame parser
// Takes one received byte per transfer and returns exactly one result per byte:
// an event code in m_tuser and the payload byte, its index, the command and the
// announced size in m_tdata. Throughput is one byte per clock cycle, sustained
// while the output is taken. A byte is held in the input register; its result is
// formed combinationally by the frame state machine and loaded into the result
// register, from which the output transfer takes it.
// Both stages advance whenever the result register is empty or being taken; while
// a finished result waits, the input register takes one more byte and then the
// input stalls.
module msp_response_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index,
	                               // [23:16] command, [31:24] frame_size
	output logic [7:0]  m_tuser    // [2:0] event_res, [7:3] zero
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          out_in_ready;
	logic          advance;
	msp_pkg::res_t res_c;
	msp_pkg::res_t res_o;

	assign advance  = valid_s1 && out_in_ready;
	assign s_tready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	msp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res_c)
	);

	msp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (out_in_ready),
		.in_res    (res_c),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res_o)
	);

	// pack output fields
	assign m_tdata = {res_o.frame_size, res_o.command, res_o.byte_index, res_o.data_byte};
	assign m_tuser = {5'd0, res_o.event_res};

endmodule

### rtl/msp_parse.sv
// frame state machine: consumes one byte per step and forms its result
module msp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       rx_byte,
	output msp_pkg::res_t    res
);

	msp_pkg::phase_t phase_q, phase_d;
	logic            err_q, err_d;
	logic [7:0]      len_q, len_d;
	logic [7:0]      cnt_q, cnt_d;
	logic [7:0]      xor_q, xor_d;
	logic [7:0]      cmd_q, cmd_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msp_pkg::PH_IDLE;
			err_q   <= 1'b0;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
			xor_q   <= 8'd0;
			cmd_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			err_q   <= err_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
			cmd_q   <= cmd_d;
		end
	end

	// next state and result
	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		xor_d   = xor_q;
		cmd_d   = cmd_q;
		res     = '{event_res: msp_pkg::EV_NONE, data_byte: 8'd0, byte_index: 8'd0,
			command: 8'd0, frame_size: 8'd0};
		case (phase_q)
			msp_pkg::PH_DOLLAR: begin
				phase_d = (rx_byte == msp_pkg::CH_M) ? msp_pkg::PH_M : msp_pkg::PH_IDLE;
			end
			msp_pkg::PH_M: begin
				if (rx_byte == msp_pkg::CH_ARROW) begin
					phase_d = msp_pkg::PH_ARROW;
				end else if (rx_byte == msp_pkg::CH_BANG) begin
					phase_d = msp_pkg::PH_ERR;
				end else begin
					phase_d = msp_pkg::PH_IDLE;
				end
			end
			msp_pkg::PH_ARROW, msp_pkg::PH_ERR: begin
				// size byte starts the checksum
				err_d   = (phase_q == msp_pkg::PH_ERR);
				len_d   = rx_byte;
				cnt_d   = 8'd0;
				xor_d   = rx_byte;
				phase_d = msp_pkg::PH_SIZE;
			end
			msp_pkg::PH_SIZE: begin
				cmd_d   = rx_byte;
				xor_d   = xor_q ^ rx_byte;
				phase_d = msp_pkg::PH_CMD;
			end
			msp_pkg::PH_CMD: begin
				res.command    = cmd_q;
				res.frame_size = len_q;
				if (cnt_q < len_q) begin
					// payload byte
					res.event_res  = msp_pkg::EV_DATA;
					res.data_byte  = rx_byte;
					res.byte_index = cnt_q;
					xor_d          = xor_q ^ rx_byte;
					cnt_d          = cnt_q + 8'd1;
				end else begin
					// checksum byte closes the frame
					if (xor_q == rx_byte) begin
						res.event_res = err_q ? msp_pkg::EV_GOODERR : msp_pkg::EV_GOOD;
					end else begin
						res.event_res = msp_pkg::EV_BADSUM;
					end
					phase_d = msp_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = (rx_byte == msp_pkg::CH_DOLLAR) ? msp_pkg::PH_DOLLAR
					: msp_pkg::PH_IDLE;
			end
		endcase
	end

endmodule

### rtl/msp_out_reg.sv
// result register with valid, decoupling the parser from the output stream
module msp_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  msp_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output msp_pkg::res_t out_res
);

	logic          valid_q;
	msp_pkg::res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule
